// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared widths, codes and types of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_BITS     = 8;
    localparam int POS_BITS    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_THREADS + 1);

    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_YIELD   = 3'd1;
    localparam logic [2:0] KIND_EXIT    = 3'd2;
    localparam logic [2:0] KIND_BLOCK   = 3'd3;
    localparam logic [2:0] KIND_DEBLOCK = 3'd4;
    localparam logic [2:0] KIND_KILL    = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_LAST       = 3'd1;
    localparam logic [2:0] ST_NOTFOUND   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_NOTSTARTED = 3'd4;

    typedef logic [ID_BITS-1:0]  id_t;
    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    // one port of a list memory: synchronous read, one write
    typedef struct packed {
        logic rd_en;
        pos_t rd_addr;
        logic wr_en;
        pos_t wr_addr;
        id_t  wr_data;
    } mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/rrts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_event_if / rrts_result_if
// Valid/ready channels for scheduler events and results.
// ----------------------------------------------------------------------------
interface rrts_event_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    rrts_pkg::id_t     thread_id;
    modport source (output valid, kind, thread_id, input ready);
    modport sink   (input valid, kind, thread_id, output ready);
endinterface

interface rrts_result_if;
    logic              valid;
    logic              ready;
    rrts_pkg::id_t     active_id;
    logic              switched;
    logic [2:0]        status;
    rrts_pkg::id_t     removed_id;
    modport source (output valid, active_id, switched, status, removed_id, input ready);
    modport sink   (input valid, active_id, switched, status, removed_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrts_list_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_list_mem
// One thread-id list: RAM with one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module rrts_list_mem (
    input  wire logic              clk,
    input  wire rrts_pkg::mem_req_t req,
    output rrts_pkg::id_t          rd_data
);
    rrts_pkg::id_t mem [rrts_pkg::MAX_THREADS];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: searches the lists one entry per cycle and shifts them entry by entry.
// ----------------------------------------------------------------------------
module rrts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    rrts_event_if.sink             evt,
    rrts_result_if.source          res,
    output rrts_pkg::mem_req_t     rq_rdy,
    output rrts_pkg::mem_req_t     rq_blk,
    input  wire rrts_pkg::id_t     rd_rdy,
    input  wire rrts_pkg::id_t     rd_blk
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH_R = 4'd1;  // scan ready list for id
    localparam logic [3:0] S_SRCH_B = 4'd2;  // scan blocked list for id
    localparam logic [3:0] S_RMV_R  = 4'd3;  // close gap in ready list
    localparam logic [3:0] S_RMV_B  = 4'd4;  // close gap in blocked list
    localparam logic [3:0] S_INS_R  = 4'd5;  // open gap in ready list
    localparam logic [3:0] S_BLKRD  = 4'd6;  // append active entry to blocked list
    localparam logic [3:0] S_ACT    = 4'd7;  // read active id
    localparam logic [3:0] S_ACTW   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam int CB = rrts_pkg::CNT_BITS;
    localparam int PB = rrts_pkg::POS_BITS;
    localparam rrts_pkg::cnt_t MAXC = CB'(rrts_pkg::MAX_THREADS);

    logic [3:0]     state_reg, state_next;
    logic [2:0]     kind_reg, kind_next;
    rrts_pkg::id_t  id_reg, id_next;
    rrts_pkg::cnt_t rcnt_reg, rcnt_next, bcnt_reg, bcnt_next;
    rrts_pkg::pos_t apos_reg, apos_next;
    logic           started_reg, started_next;
    rrts_pkg::cnt_t idx_reg, idx_next;      // scan / shift position
    logic           pend_reg, pend_next;    // read issued last cycle
    logic           found_reg, found_next;  // deblock: blocked index found
    rrts_pkg::cnt_t bidx_reg, bidx_next;
    rrts_pkg::id_t  act_reg, act_next;
    logic           sw_reg, sw_next;
    logic [2:0]     st_reg, st_next;
    rrts_pkg::id_t  rm_reg, rm_next;
    logic           ovalid_reg, ovalid_next;

    rrts_pkg::cnt_t apos_w, apos1;
    assign apos_w = CB'(apos_reg);
    assign apos1  = apos_w + CB'(1);

    assign evt.ready     = (state_reg == S_IDLE);
    assign res.valid     = ovalid_reg;
    assign res.active_id = act_reg;
    assign res.switched  = sw_reg;
    assign res.status    = st_reg;
    assign res.removed_id = rm_reg;

    // next state and memory requests
    always_comb
    begin
        state_next = state_reg; kind_next = kind_reg; id_next = id_reg;
        rcnt_next = rcnt_reg; bcnt_next = bcnt_reg; apos_next = apos_reg;
        started_next = started_reg; idx_next = idx_reg; pend_next = 1'b0;
        found_next = found_reg; bidx_next = bidx_reg; act_next = act_reg;
        sw_next = sw_reg; st_next = st_reg; rm_next = rm_reg;
        ovalid_next = ovalid_reg;
        rq_rdy = '0; rq_blk = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    kind_next = evt.kind; id_next = evt.thread_id;
                    sw_next = 1'b0; st_next = rrts_pkg::ST_OK; rm_next = '0;
                    idx_next = '0; found_next = 1'b0;
                    state_next = S_ACT;
                    if (!started_reg && evt.kind != rrts_pkg::KIND_ADD)
                    begin
                        st_next = rrts_pkg::ST_NOTSTARTED;
                        state_next = S_OUT; act_next = '0;
                    end
                    else
                    begin
                        case (evt.kind)
                            rrts_pkg::KIND_ADD:
                            begin
                                if (rcnt_reg >= MAXC)
                                    st_next = rrts_pkg::ST_FULL;
                                else
                                begin
                                    rq_rdy.wr_en = 1'b1;
                                    rq_rdy.wr_addr = rcnt_reg[PB-1:0];
                                    rq_rdy.wr_data = evt.thread_id;
                                    apos_next = rcnt_reg[PB-1:0];
                                    rcnt_next = rcnt_reg + CB'(1);
                                    started_next = 1'b1; sw_next = 1'b1;
                                end
                            end
                            rrts_pkg::KIND_YIELD:
                            begin
                                if (rcnt_reg > CB'(1))
                                begin
                                    apos_next = (apos1 < rcnt_reg) ? apos1[PB-1:0] : '0;
                                    sw_next = 1'b1;
                                end
                            end
                            rrts_pkg::KIND_EXIT:
                            begin
                                if (rcnt_reg <= CB'(1))
                                    st_next = rrts_pkg::ST_LAST;
                                else
                                begin
                                    idx_next = apos_w; state_next = S_RMV_R;
                                    sw_next = 1'b1;
                                end
                            end
                            rrts_pkg::KIND_BLOCK:
                            begin
                                if (rcnt_reg <= CB'(1))
                                    st_next = rrts_pkg::ST_LAST;
                                else if (bcnt_reg >= MAXC)
                                    st_next = rrts_pkg::ST_FULL;
                                else
                                begin
                                    rq_rdy.rd_en = 1'b1; rq_rdy.rd_addr = apos_reg;
                                    state_next = S_BLKRD; sw_next = 1'b1;
                                end
                            end
                            rrts_pkg::KIND_DEBLOCK: state_next = S_SRCH_B;
                            rrts_pkg::KIND_KILL:    state_next = S_SRCH_R;
                            default: ;
                        endcase
                    end
                end
            end
            S_BLKRD:
            begin
                rq_blk.wr_en = 1'b1; rq_blk.wr_addr = bcnt_reg[PB-1:0];
                rq_blk.wr_data = rd_rdy;
                bcnt_next = bcnt_reg + CB'(1);
                idx_next = apos_w; state_next = S_RMV_R;
            end
            S_SRCH_R:
            begin
                // read idx, compare the entry issued last cycle
                if (pend_reg && rd_rdy == id_reg)
                begin
                    rm_next = id_reg;
                    if (rcnt_reg <= CB'(1))
                    begin
                        st_next = rrts_pkg::ST_LAST; rm_next = '0;
                        state_next = S_ACT;
                    end
                    else
                    begin
                        idx_next = idx_reg - CB'(1);
                        if ((idx_reg - CB'(1)) == apos_w)
                            sw_next = 1'b1;
                        else if ((idx_reg - CB'(1)) < apos_w)
                            apos_next = apos_reg - PB'(1);
                        state_next = S_RMV_R;
                    end
                end
                else if (idx_reg < rcnt_reg)
                begin
                    rq_rdy.rd_en = 1'b1; rq_rdy.rd_addr = idx_reg[PB-1:0];
                    idx_next = idx_reg + CB'(1); pend_next = 1'b1;
                end
                else
                begin
                    idx_next = '0; state_next = S_SRCH_B;
                end
            end
            S_SRCH_B:
            begin
                if (pend_reg && rd_blk == id_reg)
                begin
                    bidx_next = idx_reg - CB'(1);
                    if (kind_reg == rrts_pkg::KIND_KILL)
                    begin
                        rm_next = id_reg; idx_next = idx_reg - CB'(1);
                        state_next = S_RMV_B;
                    end
                    else if (rcnt_reg >= MAXC)
                    begin
                        st_next = rrts_pkg::ST_FULL; state_next = S_ACT;
                    end
                    else
                    begin
                        found_next = 1'b1; idx_next = rcnt_reg;
                        state_next = S_INS_R;
                    end
                end
                else if (idx_reg < bcnt_reg)
                begin
                    rq_blk.rd_en = 1'b1; rq_blk.rd_addr = idx_reg[PB-1:0];
                    idx_next = idx_reg + CB'(1); pend_next = 1'b1;
                end
                else
                begin
                    st_next = rrts_pkg::ST_NOTFOUND; state_next = S_ACT;
                end
            end
            S_RMV_R:
            begin
                // list[idx] = list[idx+1]: read then write for each entry
                if (pend_reg)
                begin
                    rq_rdy.wr_en = 1'b1; rq_rdy.wr_addr = idx_reg[PB-1:0];
                    rq_rdy.wr_data = rd_rdy; idx_next = idx_reg + CB'(1);
                end
                else if (idx_reg + CB'(1) < rcnt_reg)
                begin
                    rq_rdy.rd_en = 1'b1;
                    rq_rdy.rd_addr = PB'(idx_reg + CB'(1));
                    pend_next = 1'b1;
                end
                else
                begin
                    rcnt_next = rcnt_reg - CB'(1);
                    if (apos_w >= rcnt_reg - CB'(1))
                        apos_next = '0;
                    state_next = S_ACT;
                end
            end
            S_RMV_B:
            begin
                if (pend_reg)
                begin
                    rq_blk.wr_en = 1'b1; rq_blk.wr_addr = idx_reg[PB-1:0];
                    rq_blk.wr_data = rd_blk; idx_next = idx_reg + CB'(1);
                end
                else if (idx_reg + CB'(1) < bcnt_reg)
                begin
                    rq_blk.rd_en = 1'b1;
                    rq_blk.rd_addr = PB'(idx_reg + CB'(1));
                    pend_next = 1'b1;
                end
                else
                begin
                    bcnt_next = bcnt_reg - CB'(1); state_next = S_ACT;
                end
            end
            S_INS_R:
            begin
                // list[i] = list[i-1] for i from count down to apos+2
                if (pend_reg)
                begin
                    rq_rdy.wr_en = 1'b1; rq_rdy.wr_addr = idx_reg[PB-1:0];
                    rq_rdy.wr_data = rd_rdy; idx_next = idx_reg - CB'(1);
                end
                else if (idx_reg > apos1)
                begin
                    rq_rdy.rd_en = 1'b1;
                    rq_rdy.rd_addr = PB'(idx_reg - CB'(1));
                    pend_next = 1'b1;
                end
                else
                begin
                    rq_rdy.wr_en = 1'b1; rq_rdy.wr_addr = apos1[PB-1:0];
                    rq_rdy.wr_data = id_reg;
                    rcnt_next = rcnt_reg + CB'(1);
                    idx_next = bidx_reg; state_next = S_RMV_B;
                end
            end
            S_ACT:
            begin
                if (rcnt_reg != '0)
                begin
                    rq_rdy.rd_en = 1'b1; rq_rdy.rd_addr = apos_reg;
                end
                state_next = S_ACTW;
            end
            S_ACTW:
            begin
                act_next = (rcnt_reg != '0) ? rd_rdy : '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                if (ovalid_reg && res.ready)
                begin
                    ovalid_next = 1'b0; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; rcnt_reg <= '0; bcnt_reg <= '0;
            apos_reg <= '0; started_reg <= 1'b0; ovalid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; rcnt_reg <= rcnt_next; bcnt_reg <= bcnt_next;
            apos_reg <= apos_next; started_reg <= started_next;
            ovalid_reg <= ovalid_next; pend_reg <= pend_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next; id_reg <= id_next; idx_reg <= idx_next;
        found_reg <= found_next; bidx_reg <= bidx_next; act_reg <= act_next;
        sw_reg <= sw_next; st_reg <= st_next; rm_reg <= rm_next;
    end
endmodule
`default_nettype wire

// ===== rtl/round_robin_thread_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit
// Ready and blocked thread lists in RAM, with an event sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  evt     | in  | kind, thread_id
//  res     | out | active_id, switched, status, removed_id
//
//  One event at a time; kill and deblock take longest, set by the search
//  and shift through each list's RAM (read, then write, per moved entry).
//  Reset clears counts and position; list contents are not cleared.
//  A held result stalls further events until taken.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rrts_event_if.sink    evt,
    rrts_result_if.source res
);
    rrts_pkg::mem_req_t rq_rdy, rq_blk;
    rrts_pkg::id_t      rd_rdy, rd_blk;

    rrts_list_mem u_ready (.clk(clk), .req(rq_rdy), .rd_data(rd_rdy));
    rrts_list_mem u_blocked (.clk(clk), .req(rq_blk), .rd_data(rd_blk));

    rrts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .evt(evt), .res(res),
        .rq_rdy(rq_rdy), .rq_blk(rq_blk), .rd_rdy(rd_rdy), .rd_blk(rd_blk)
    );
endmodule
`default_nettype wire

// ===== verif/round_robin_thread_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit_tb
// Drives scheduler events through the request channel, predicts each result
// from a behavioural copy of the ready and blocked lists, and compares the
// results field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit_tb;
    import rrts_pkg::*;

    typedef struct packed {
        id_t        active_id;
        logic       switched;
        logic [2:0] status;
        id_t        removed_id;
    } sched_res_t;

    // Behavioural scheduler state plus queue of expected results
    class sched_scoreboard;
        id_t        rdy[$];
        id_t        blk[$];
        int         apos;
        bit         started;
        sched_res_t pending[$];
        int         errors;
        int         checked;

        function void note_request(logic [2:0] kind, id_t id);
            sched_res_t r;
            int         idx;
            r = '0;
            idx = -1;
            if (!started && kind != KIND_ADD)
                r.status = ST_NOTSTARTED;
            else
            begin
                case (kind)
                    KIND_ADD:
                        if (rdy.size() >= MAX_THREADS) r.status = ST_FULL;
                        else
                        begin
                            rdy = {rdy, id};
                            apos = rdy.size() - 1;
                            started = 1;
                            r.switched = 1;
                        end
                    KIND_YIELD:
                        if (rdy.size() > 1)
                        begin
                            apos = (apos + 1 < rdy.size()) ? apos + 1 : 0;
                            r.switched = 1;
                        end
                    KIND_EXIT:
                        if (rdy.size() <= 1) r.status = ST_LAST;
                        else
                        begin
                            drop_active();
                            r.switched = 1;
                        end
                    KIND_BLOCK:
                        if (rdy.size() <= 1) r.status = ST_LAST;
                        else if (blk.size() >= MAX_THREADS) r.status = ST_FULL;
                        else
                        begin
                            blk = {blk, rdy[apos]};
                            drop_active();
                            r.switched = 1;
                        end
                    KIND_DEBLOCK:
                    begin
                        idx = find(blk, id);
                        if (idx < 0) r.status = ST_NOTFOUND;
                        else if (rdy.size() >= MAX_THREADS) r.status = ST_FULL;
                        else
                        begin
                            rdy.insert(apos + 1, id);
                            blk.delete(idx);
                        end
                    end
                    KIND_KILL:
                    begin
                        idx = find(rdy, id);
                        if (idx >= 0)
                        begin
                            if (rdy.size() <= 1) r.status = ST_LAST;
                            else if (idx == apos)
                            begin
                                drop_active();
                                r.switched = 1;
                                r.removed_id = id;
                            end
                            else
                            begin
                                rdy.delete(idx);
                                if (idx < apos) apos--;
                                r.removed_id = id;
                            end
                        end
                        else
                        begin
                            idx = find(blk, id);
                            if (idx < 0) r.status = ST_NOTFOUND;
                            else
                            begin
                                blk.delete(idx);
                                r.removed_id = id;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.active_id = (rdy.size() > 0 && apos < rdy.size()) ? rdy[apos] : '0;
            pending = {pending, r};
        endfunction

        function void drop_active();
            rdy.delete(apos);
            if (apos >= rdy.size()) apos = 0;
        endfunction

        function int find(id_t l[$], id_t id);
            foreach (l[i])
                if (l[i] == id) return i;
            return -1;
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.active_id !== e.active_id)
            begin
                $error("active_id exp %0d got %0d", e.active_id, got.active_id);
                errors++;
            end
            if (got.switched !== e.switched)
            begin
                $error("switched exp %0d got %0d", e.switched, got.switched);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.removed_id !== e.removed_id)
            begin
                $error("removed_id exp %0d got %0d", e.removed_id, got.removed_id);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rrts_event_if  evt ();
    rrts_result_if res ();

    round_robin_thread_scheduler_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt.sink),
        .res   (res.source)
    );

    sched_scoreboard sb;
    longint cycles;
    bit     calm;
    int     n_sent;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout waiting for results");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, compare on handshake
    initial
    begin
        int stall;
        res.ready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
                sb.check_result({res.active_id, res.switched, res.status, res.removed_id});
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9);
                res.ready <= 0;
                repeat (stall)
                begin
                    @(posedge clk);
                end
                res.ready <= 1;
            end
            else
                res.ready <= 1;
        end
    end

    // One request; the valid stays high across back-to-back requests
    task automatic send(logic [2:0] kind, id_t id);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            evt.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        evt.valid     <= 1;
        evt.kind      <= kind;
        evt.thread_id <= id;
        do @(posedge clk); while (!evt.ready);
        sb.note_request(kind, id);
        n_sent++;
    endtask

    task automatic drain();
        evt.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Thread ids drawn mostly from a small pool so searches hit
    function automatic id_t pick_id();
        if ($urandom_range(0, 9) == 0) return id_t'($urandom);
        return id_t'($urandom_range(0, 23));
    endfunction

    initial
    begin
        int k;
        sb = new();
        cycles = 0;
        calm = 0;
        n_sent = 0;
        evt.valid = 0;
        evt.kind = KIND_ADD;
        evt.thread_id = '0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: not started, extremes, last-thread refusals, fills
        send(KIND_YIELD, 8'd0);
        send(KIND_KILL, 8'd5);
        send(3'd7, 8'd0);
        send(KIND_ADD, 8'hFF);
        send(KIND_YIELD, 8'd0);
        send(KIND_EXIT, 8'd0);
        send(KIND_BLOCK, 8'd0);
        send(KIND_KILL, 8'hFF);
        send(KIND_DEBLOCK, 8'd9);
        send(KIND_KILL, 8'd9);
        send(KIND_ADD, 8'h00);
        send(KIND_ADD, 8'hFF);
        send(KIND_BLOCK, 8'd0);
        send(KIND_KILL, 8'hFF);
        send(KIND_DEBLOCK, 8'hFF);
        send(3'd6, 8'hAA);
        for (int i = 0; i < 17; i++) send(KIND_ADD, id_t'(8'h55 + i));
        send(KIND_DEBLOCK, 8'h00);
        drain();

        // Random: mixed events, sender holds off at times until drained
        for (int i = 0; i < 1700; i++)
        begin
            if (i > 1500) calm = 1;
            if (i % 400 == 399) drain();
            k = $urandom_range(0, 99);
            if (k < 22) send(KIND_ADD, pick_id());
            else if (k < 40) send(KIND_YIELD, id_t'($urandom));
            else if (k < 50) send(KIND_EXIT, id_t'($urandom));
            else if (k < 64) send(KIND_BLOCK, id_t'($urandom));
            else if (k < 80) send(KIND_DEBLOCK, pick_id());
            else if (k < 97) send(KIND_KILL, pick_id());
            else send(3'($urandom_range(6, 7)), id_t'($urandom));
        end
        drain();

        $display("sent %0d scheduler events, checked %0d results", n_sent, sb.checked);
        $display("covered add/yield/exit/block/deblock/kill incl. full, last and absent ids");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_list_mem.sv
rtl/rrts_ctrl.sv
rtl/round_robin_thread_scheduler_unit.sv
verif/round_robin_thread_scheduler_unit_tb.sv
